[hdl/hbt_pkg.sv]
// Shared types and constants of the bucketed hash table.
`default_nettype none

package hbt_pkg;

  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int MOD_BITS    = 4;
  localparam int MOD_STEPS   = 8;
  localparam int MOD_CNT_W   = 3;
  localparam int KEY_PAD_W   = MOD_BITS * MOD_STEPS;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_SEARCH,
    OP_LIST
  } op_t;

  typedef enum logic [1:0] {
    RES_DONE,
    RES_NOT_FOUND,
    RES_FULL,
    RES_EMPTY
  } res_status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MSTART,
    S_MWAIT,
    S_FILL,
    S_INS,
    S_RD,
    S_CMP,
    S_MRD,
    S_MWR,
    S_RMFIN,
    S_LRD,
    S_LOUT,
    S_RES
  } ctl_state_t;

  typedef struct packed {
    logic        in_ready;
    logic        clr_wr;
    logic        mod_start;
    logic        fill_rd;
    logic        fill_wr;
    logic        fill_dec;
    logic        idx_clr;
    logic        idx_inc;
    logic        slot_rd;
    logic        rd_next;
    logic        slot_wr;
    logic        wr_move;
    logic        hit_set;
    logic        emit;
    res_status_t res_status;
    logic        res_found;
    logic        res_value;
    logic        res_last;
  } hbt_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
    logic fill_full;
    logic fill_zero;
    logic key_match;
    logic idx_last;
    logic mv_more;
    logic out_free;
    op_t  op;
  } hbt_stat_t;

endpackage

`default_nettype wire

[hdl/hbt_bucket_idx.sv]
// Bucket index unit: key modulo the bucket count.
`default_nettype none

module hbt_bucket_idx #(
  parameter int BUCKETS = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [hbt_pkg::KEY_W-1:0]         key,
  output logic                                   done,
  output logic [$clog2(BUCKETS)-1:0]             bucket
);
  import hbt_pkg::*;

  localparam int  BW   = $clog2(BUCKETS);
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      assign bucket = key[BW-1:0];
      assign done   = 1'b1;
    end else begin : g_iter
      logic [BW-1:0]        rem_r;
      logic [BW-1:0]        rem_nxt;
      logic [BW:0]          t_c;
      logic [KEY_PAD_W-1:0] sh_r;
      logic [MOD_CNT_W-1:0] cnt_r;
      logic                 busy_r;

      // restoring reduction, MOD_BITS key bits per cycle, MSB first
      always_comb begin
        rem_nxt = rem_r;
        t_c     = '0;
        for (int s = 0; s < MOD_BITS; s++) begin
          t_c = {rem_nxt, sh_r[KEY_PAD_W-1-s]};
          if (t_c >= (BW+1)'(BUCKETS)) begin
            t_c = t_c - (BW+1)'(BUCKETS);
          end
          rem_nxt = t_c[BW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          cnt_r  <= '0;
        end else if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end else if (busy_r) begin
          cnt_r <= cnt_r + MOD_CNT_W'(1);
          if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_r <= 1'b0;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          sh_r  <= KEY_PAD_W'(key);
          rem_r <= '0;
        end else if (busy_r) begin
          sh_r  <= sh_r << MOD_BITS;
          rem_r <= rem_nxt;
        end
      end

      assign done   = !busy_r;
      assign bucket = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

[hdl/hbt_datapath.sv]
// Datapath: request registers, slot and fill memories, compare logic, result register.
`default_nettype none

module hbt_datapath #(
  parameter int BUCKETS          = 128,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hbt_pkg::hbt_cmd_t                   cmd,
  output hbt_pkg::hbt_stat_t                       stat,
  input  wire logic                                in_tvalid,
  input  wire logic [hbt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic [1:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hbt_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic [1:0]                               out_tuser,
  output logic                                     out_tlast
);
  import hbt_pkg::*;

  localparam int BW          = $clog2(BUCKETS);
  localparam int FW          = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int SLOTS_TOTAL = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW          = $clog2(SLOTS_TOTAL);

  op_t             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic [BW-1:0]   mod_bucket;
  logic            mod_done;
  logic [BW-1:0]   bucket_r;
  logic [AW-1:0]   base_r;
  logic [FW-1:0]   fill_rd_r;
  logic [FW-1:0]   idx_r;
  logic            hit_r;
  logic [BW-1:0]   clr_r;

  logic [KEY_W-1:0] key_mem [SLOTS_TOTAL];
  logic [VAL_W-1:0] val_mem [SLOTS_TOTAL];
  logic [FW-1:0]    fill_mem [BUCKETS];

  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;
  logic [BW-1:0]    fill_wa;
  logic [FW-1:0]    fill_wd;

  logic             out_valid_r;
  res_status_t      out_status_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r;

  hbt_bucket_idx #(
    .BUCKETS(BUCKETS)
  ) u_bucket_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .key   (key_r),
    .done  (mod_done),
    .bucket(mod_bucket)
  );

  // capture the request word
  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_tvalid) begin
      op_r  <= op_t'(in_tuser);
      key_r <= in_tdata[KEY_W-1:0];
      val_r <= in_tdata[KEY_W +: VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      bucket_r  <= mod_bucket;
      base_r    <= AW'(mod_bucket) * AW'(SLOTS_PER_BUCKET);
      fill_rd_r <= fill_mem[mod_bucket];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + FW'(1);
      end
      if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
    end
  end

  // clearing pass over the fill counts after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + BW'(1);
    end
  end

  assign fill_wa = cmd.clr_wr ? clr_r : bucket_r;
  always_comb begin
    if (cmd.clr_wr) begin
      fill_wd = '0;
    end else if (cmd.fill_dec) begin
      fill_wd = fill_rd_r - FW'(1);
    end else begin
      fill_wd = fill_rd_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.fill_wr) begin
      fill_mem[fill_wa] <= fill_wd;
    end
  end

  assign rd_addr = base_r + AW'(idx_r) + (cmd.rd_next ? AW'(1) : AW'(0));
  assign wr_addr = base_r + AW'(cmd.wr_move ? idx_r : fill_rd_r);
  assign wr_key  = cmd.wr_move ? rd_key_r : key_r;
  assign wr_val  = cmd.wr_move ? rd_val_r : val_r;

  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd.slot_rd) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  // result register, loaded only when free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.res_status;
      out_found_r  <= cmd.res_found & hit_r;
      out_value_r  <= cmd.res_value ? rd_val_r : '0;
      out_last_r   <= cmd.res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - VAL_W - 1){1'b0}}, out_value_r, out_found_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    stat.mod_done  = mod_done;
    stat.clr_last  = (clr_r == BW'(BUCKETS - 1));
    stat.fill_full = (fill_rd_r >= FW'(SLOTS_PER_BUCKET));
    stat.fill_zero = (fill_rd_r == '0);
    stat.key_match = (rd_key_r == key_r);
    stat.idx_last  = ((FW+1)'(idx_r) + (FW+1)'(1)) == (FW+1)'(fill_rd_r);
    stat.mv_more   = ((FW+1)'(idx_r) + (FW+1)'(2)) < (FW+1)'(fill_rd_r);
    stat.out_free  = !out_valid_r || out_tready;
    stat.op        = op_r;
  end

endmodule

`default_nettype wire

[hdl/hbt_ctrl.sv]
// Controller state machine sequencing insert, remove, search and list.
`default_nettype none

module hbt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire hbt_pkg::hbt_stat_t stat,
  output hbt_pkg::hbt_cmd_t       cmd
);
  import hbt_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_MSTART;
      end
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (stat.mod_done) state_nxt = S_FILL;
      end
      S_FILL: begin
        case (stat.op)
          OP_INSERT: state_nxt = S_INS;
          OP_LIST:   state_nxt = stat.fill_zero ? S_RES : S_LRD;
          default:   state_nxt = stat.fill_zero ? S_RES : S_RD;
        endcase
      end
      S_INS: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (stat.key_match) begin
          if (stat.op == OP_SEARCH) begin
            state_nxt = S_RES;
          end else begin
            state_nxt = stat.idx_last ? S_RMFIN : S_MRD;
          end
        end else begin
          state_nxt = stat.idx_last ? S_RES : S_RD;
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: state_nxt = stat.mv_more ? S_MRD : S_RMFIN;
      S_RMFIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_LRD: state_nxt = S_LOUT;
      S_LOUT: begin
        if (stat.out_free) state_nxt = stat.idx_last ? S_IDLE : S_LRD;
      end
      S_RES: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLR:    cmd.clr_wr    = 1'b1;
      S_IDLE:   cmd.in_ready  = 1'b1;
      S_MSTART: cmd.mod_start = 1'b1;
      S_MWAIT:  cmd.fill_rd   = stat.mod_done;
      S_FILL:   cmd.idx_clr   = 1'b1;
      S_INS: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.res_last = 1'b1;
          if (stat.fill_full) begin
            cmd.res_status = RES_FULL;
          end else begin
            cmd.res_status = RES_DONE;
            cmd.slot_wr    = 1'b1;
            cmd.fill_wr    = 1'b1;
          end
        end
      end
      S_RD: cmd.slot_rd = 1'b1;
      S_CMP: begin
        if (stat.key_match) begin
          cmd.hit_set = (stat.op == OP_SEARCH);
        end else begin
          cmd.idx_inc = !stat.idx_last;
        end
      end
      S_MRD: begin
        cmd.slot_rd = 1'b1;
        cmd.rd_next = 1'b1;
      end
      S_MWR: begin
        // shift the next entry down over the gap
        cmd.slot_wr = 1'b1;
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_RMFIN: begin
        if (stat.out_free) begin
          cmd.fill_wr    = 1'b1;
          cmd.fill_dec   = 1'b1;
          cmd.emit       = 1'b1;
          cmd.res_status = RES_DONE;
          cmd.res_last   = 1'b1;
        end
      end
      S_LRD: cmd.slot_rd = 1'b1;
      S_LOUT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.res_status = RES_DONE;
          cmd.res_value  = 1'b1;
          cmd.res_last   = stat.idx_last;
          cmd.idx_inc    = !stat.idx_last;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.res_last  = 1'b1;
          cmd.res_found = (stat.op == OP_SEARCH);
          case (stat.op)
            OP_REMOVE: cmd.res_status = RES_NOT_FOUND;
            OP_LIST:   cmd.res_status = RES_EMPTY;
            default:   cmd.res_status = RES_DONE;
          endcase
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/bucketed_hash_table.sv]
// Top level of the bucketed hash table.
`default_nettype none

// Hash table of BUCKETS buckets, each holding up to SLOTS_PER_BUCKET key/value
// pairs in insertion order; the bucket is the key modulo BUCKETS. One request
// word is taken at a time (in_tuser: 0 insert, 1 remove, 2 search, 3 list).
// Insert returns one result word; search and remove compare the stored keys in
// turn, and remove then moves each later entry down over the gap; list emits
// one value per entry, or one result word for an empty bucket. The slot memory
// read is registered, so each slot step is a read state followed by a compare,
// move or output state. Every step that loads a result word also waits while
// the previous result word is still held unaccepted in the output register.
// When BUCKETS is not a power of two the key reduction unit works through the
// key MOD_BITS bits at a time and every request waits for it. After reset the
// fill counts are swept to zero, one bucket a cycle, before the first request
// word is accepted. A result word may wait in the output register while the
// next request word is accepted.
module bucketed_hash_table #(
  parameter int BUCKETS          = 128,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [hbt_pkg::IN_TDATA_W-1:0]      in_tdata,  // lookup_key[30:0], entry_value[62:31]
  input  wire logic [1:0]                          in_tuser,  // operation[1:0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hbt_pkg::OUT_TDATA_W-1:0]          out_tdata, // found[0], listed_value[32:1]
  output logic [1:0]                               out_tuser, // status[1:0]
  output logic                                     out_tlast
);
  import hbt_pkg::*;

  hbt_cmd_t  cmd;
  hbt_stat_t stat;

  hbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbt_datapath #(
    .BUCKETS         (BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  assign in_tready = cmd.in_ready;

endmodule

`default_nettype wire
